[src/pig_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pig_pkg
// Shared widths, limits and a helper function for the prime implicant unit.
// ----------------------------------------------------------------------------
package pig_pkg;

  localparam int unsigned MaxVars = 6;
  localparam int unsigned RowW    = 1 << MaxVars;
  localparam int unsigned AddrW   = MaxVars;
  localparam int unsigned BitW    = 3;
  localparam int unsigned CntW    = 7;
  localparam int unsigned MaxOut  = 64;

  typedef logic [RowW-1:0]  row_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [BitW-1:0]  bit_idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  // positions whose index has variable bit b clear
  function automatic row_t low_sel(input bit_idx_t b);
    row_t  r;
    addr_t idx;
    for (int v = 0; v < RowW; v++) begin
      idx  = AddrW'(v);
      r[v] = ~idx[b];
    end
    return r;
  endfunction

endpackage

[src/pig_merge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pig_merge_unit
// Combines all adjacent cube pairs of one row along one variable.
// ----------------------------------------------------------------------------
module pig_merge_unit (
  input  pig_pkg::row_t     cur_i,
  input  pig_pkg::bit_idx_t bit_i,
  input  pig_pkg::row_t     old_i,
  output pig_pkg::row_t     new_row_o,
  output pig_pkg::row_t     merged_o
);

  pig_pkg::row_t partner;
  pig_pkg::row_t pairs;
  pig_pkg::row_t pairs_up;

  always_comb begin
    case (bit_i)
      3'd0:    partner = cur_i >> 1;
      3'd1:    partner = cur_i >> 2;
      3'd2:    partner = cur_i >> 4;
      3'd3:    partner = cur_i >> 8;
      3'd4:    partner = cur_i >> 16;
      default: partner = cur_i >> 32;
    endcase
    pairs = cur_i & partner & pig_pkg::low_sel(bit_i);
    case (bit_i)
      3'd0:    pairs_up = pairs << 1;
      3'd1:    pairs_up = pairs << 2;
      3'd2:    pairs_up = pairs << 4;
      3'd3:    pairs_up = pairs << 8;
      3'd4:    pairs_up = pairs << 16;
      default: pairs_up = pairs << 32;
    endcase
  end

  assign new_row_o = old_i | pairs;
  assign merged_o  = pairs | pairs_up;

endmodule

[src/pig_lsb_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pig_lsb_scan
// Finds the lowest set bit of a row and returns the row with it cleared.
// ----------------------------------------------------------------------------
module pig_lsb_scan (
  input  pig_pkg::row_t  word_i,
  output pig_pkg::addr_t index_o,
  output pig_pkg::row_t  rest_o
);

  always_comb begin
    index_o = '0;
    for (int i = pig_pkg::RowW - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        index_o = pig_pkg::AddrW'(i);
      end
    end
  end

  assign rest_o = word_i & (word_i - pig_pkg::row_t'(1));

endmodule

[src/pig_prime_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pig_prime_count
// Two-stage population count of prime rows, saturating just above the limit.
// ----------------------------------------------------------------------------
module pig_prime_count (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clear_i,
  input  logic           row_valid_i,
  input  pig_pkg::row_t  row_i,
  output pig_pkg::cnt_t  total_o
);

  localparam int unsigned Bytes = pig_pkg::RowW / 8;
  localparam int unsigned Sat   = pig_pkg::MaxOut + 1;

  logic [3:0]        byte_cnt_d [Bytes];
  logic [3:0]        byte_cnt_q [Bytes];
  logic              stage_vld_q;
  pig_pkg::cnt_t     total_q;
  pig_pkg::cnt_t     row_sum;
  logic [pig_pkg::CntW:0] acc;

  always_comb begin
    for (int j = 0; j < Bytes; j++) begin
      byte_cnt_d[j] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt_d[j] = byte_cnt_d[j] + 4'(row_i[j*8+i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Bytes; j++) begin
      byte_cnt_q[j] <= byte_cnt_d[j];
    end
  end

  always_comb begin
    row_sum = '0;
    for (int j = 0; j < Bytes; j++) begin
      row_sum = row_sum + pig_pkg::CntW'(byte_cnt_q[j]);
    end
    acc = {1'b0, total_q} + {1'b0, row_sum};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      total_q     <= '0;
    end else begin
      stage_vld_q <= row_valid_i & ~clear_i;
      if (clear_i) begin
        total_q <= '0;
      end else if (stage_vld_q) begin
        if (acc > (pig_pkg::CntW+1)'(Sat)) begin
          total_q <= pig_pkg::CntW'(Sat);
        end else begin
          total_q <= acc[pig_pkg::CntW-1:0];
        end
      end
    end
  end

  assign total_o = total_q;

endmodule

[src/prime_implicant_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_implicant_generator_unit
// Quine-McCluskey prime implicant generation for truth tables of 2 to 6
// variables.
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start is high and busy is low; truth_table_i
//   and var_count_i are sampled at that edge. var_count_i is clamped to 2..6
//   and table bits beyond 2^var_count are ignored.
//   results come out one per cycle at most on valid_o with implicant_value_o,
//   dont_care_mask_o, last_implicant_o, truncated_o and empty_function_o,
//   ordered by mask then value; each is shown for exactly one cycle.
//   an all-zero table gives a single empty_function result in the cycle after
//   the transaction, and busy never rises.
//   otherwise one merge pass runs over every mask row: each row but the first
//   is loaded (ST_LATCH), then each variable not yet eliminated costs a
//   read-modify-write of the target row through the shared merge unit
//   (ST_STEP, ST_WRITE), and a last ST_STEP closes the row. emission then
//   latches and scans one prime row at a time (ST_E_LATCH, ST_E_SCAN), shows
//   one prime per scan step and stops at the last prime.
//   busy stays high from the transaction until the edge that shows the last
//   result.
//   reset clears the sequencer, valid bits and count; the receiver cannot
//   stall, results are never held.
// ----------------------------------------------------------------------------
module prime_implicant_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] truth_table_i,
  input  logic [2:0]  var_count_i,
  output logic        valid_o,
  output logic [5:0]  implicant_value_o,
  output logic [5:0]  dont_care_mask_o,
  output logic        last_implicant_o,
  output logic        truncated_o,
  output logic        empty_function_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LATCH   = 6'b000010,
    ST_STEP    = 6'b000100,
    ST_WRITE   = 6'b001000,
    ST_E_LATCH = 6'b010000,
    ST_E_SCAN  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  pig_pkg::addr_t    m_q, m_d;
  pig_pkg::addr_t    last_m_q, last_m_d;
  pig_pkg::addr_t    rem_q, rem_d;
  pig_pkg::bit_idx_t b_q, b_d;
  pig_pkg::row_t     cur_q, cur_d;
  pig_pkg::row_t     merged_q, merged_d;
  pig_pkg::row_t     work_q, work_d;
  pig_pkg::cnt_t     k_q, k_d;
  pig_pkg::row_t     valid_q, valid_d;

  logic              out_vld_q, out_vld_d;
  pig_pkg::addr_t    out_val_q, out_val_d;
  pig_pkg::addr_t    out_msk_q, out_msk_d;
  logic              out_last_q, out_last_d;
  logic              out_trunc_q, out_trunc_d;
  logic              out_empty_q, out_empty_d;

  pig_pkg::row_t     present_mem [pig_pkg::RowW];
  pig_pkg::row_t     prime_mem [pig_pkg::RowW];
  pig_pkg::row_t     pres_rd_q;
  logic              pres_rvld_q;
  pig_pkg::row_t     prime_rd_q;

  pig_pkg::addr_t    pres_raddr;
  logic              pres_we;
  pig_pkg::addr_t    pres_waddr;
  pig_pkg::row_t     pres_wdata;
  logic              prime_we;
  pig_pkg::addr_t    prime_raddr;

  logic              accept;
  logic [2:0]        nv;
  pig_pkg::addr_t    vars_mask;
  pig_pkg::row_t     table_masked;
  pig_pkg::bit_idx_t rem_low;
  pig_pkg::addr_t    rem_bit;
  pig_pkg::addr_t    wr_bit;
  pig_pkg::row_t     old_row;
  pig_pkg::row_t     merge_row;
  pig_pkg::row_t     merge_add;
  pig_pkg::addr_t    scan_idx;
  pig_pkg::row_t     scan_rest;
  logic              pop_clear;
  logic              pop_vld;
  pig_pkg::cnt_t     total;
  logic              trunc;
  pig_pkg::cnt_t     eff_total;
  logic              is_last;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    if (var_count_i < 3'd2) begin
      nv = 3'd2;
    end else if (var_count_i > 3'(pig_pkg::MaxVars)) begin
      nv = 3'(pig_pkg::MaxVars);
    end else begin
      nv = var_count_i;
    end
    vars_mask = pig_pkg::AddrW'((7'd1 << nv) - 7'd1);
    for (int i = 0; i < pig_pkg::RowW; i++) begin
      table_masked[i] = truth_table_i[i] & (pig_pkg::AddrW'(i) <= vars_mask);
    end
  end

  always_comb begin
    rem_low = '0;
    for (int i = pig_pkg::AddrW - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        rem_low = pig_pkg::BitW'(i);
      end
    end
  end

  assign rem_bit = pig_pkg::addr_t'(1) << rem_low;
  assign wr_bit  = pig_pkg::addr_t'(1) << b_q;
  assign old_row = pres_rvld_q ? pres_rd_q : '0;

  pig_merge_unit u_merge (
    .cur_i     (cur_q),
    .bit_i     (b_q),
    .old_i     (old_row),
    .new_row_o (merge_row),
    .merged_o  (merge_add)
  );

  pig_lsb_scan u_scan (
    .word_i  (work_q),
    .index_o (scan_idx),
    .rest_o  (scan_rest)
  );

  pig_prime_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (pop_clear),
    .row_valid_i (pop_vld),
    .row_i       (cur_q & ~merged_q),
    .total_o     (total)
  );

  assign trunc     = (total > pig_pkg::CntW'(pig_pkg::MaxOut));
  assign eff_total = trunc ? pig_pkg::CntW'(pig_pkg::MaxOut) : total;
  assign is_last   = ((k_q + pig_pkg::cnt_t'(1)) == eff_total);

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    last_m_d    = last_m_q;
    rem_d       = rem_q;
    b_d         = b_q;
    cur_d       = cur_q;
    merged_d    = merged_q;
    work_d      = work_q;
    k_d         = k_q;
    valid_d     = valid_q;
    out_vld_d   = 1'b0;
    out_val_d   = out_val_q;
    out_msk_d   = out_msk_q;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    out_empty_d = out_empty_q;
    pres_raddr  = m_q;
    pres_we     = 1'b0;
    pres_waddr  = m_q | wr_bit;
    pres_wdata  = merge_row;
    prime_we    = 1'b0;
    prime_raddr = m_q;
    pop_clear   = 1'b0;
    pop_vld     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (table_masked == '0) begin
            out_vld_d   = 1'b1;
            out_val_d   = '0;
            out_msk_d   = '0;
            out_last_d  = 1'b1;
            out_trunc_d = 1'b0;
            out_empty_d = 1'b1;
          end else begin
            pop_clear  = 1'b1;
            pres_we    = 1'b1;
            pres_waddr = '0;
            pres_wdata = table_masked;
            valid_d    = pig_pkg::row_t'(1);
            last_m_d   = vars_mask;
            m_d        = '0;
            rem_d      = vars_mask;
            cur_d      = table_masked;
            merged_d   = '0;
            state_d    = ST_STEP;
          end
        end
      end
      ST_LATCH: begin
        cur_d    = old_row;
        merged_d = '0;
        rem_d    = last_m_q & ~m_q;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        if (rem_q != '0) begin
          pres_raddr = m_q | rem_bit;
          b_d        = rem_low;
          rem_d      = rem_q & ~rem_bit;
          state_d    = ST_WRITE;
        end else begin
          prime_we = 1'b1;
          pop_vld  = 1'b1;
          if (m_q == last_m_q) begin
            prime_raddr = '0;
            m_d         = '0;
            k_d         = '0;
            state_d     = ST_E_LATCH;
          end else begin
            pres_raddr = m_q + pig_pkg::addr_t'(1);
            m_d        = m_q + pig_pkg::addr_t'(1);
            state_d    = ST_LATCH;
          end
        end
      end
      ST_WRITE: begin
        pres_we             = 1'b1;
        valid_d[pres_waddr] = 1'b1;
        merged_d            = merged_q | merge_add;
        state_d             = ST_STEP;
      end
      ST_E_LATCH: begin
        work_d  = prime_rd_q;
        state_d = ST_E_SCAN;
      end
      ST_E_SCAN: begin
        if (work_q != '0) begin
          out_vld_d   = 1'b1;
          out_val_d   = scan_idx;
          out_msk_d   = m_q;
          out_last_d  = is_last;
          out_trunc_d = trunc;
          out_empty_d = 1'b0;
          work_d      = scan_rest;
          k_d         = k_q + pig_pkg::cnt_t'(1);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end else begin
          prime_raddr = m_q + pig_pkg::addr_t'(1);
          m_d         = m_q + pig_pkg::addr_t'(1);
          state_d     = ST_E_LATCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pres_we) begin
      present_mem[pres_waddr] <= pres_wdata;
    end
    pres_rd_q <= present_mem[pres_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prime_we) begin
      prime_mem[m_q] <= cur_q & ~merged_q;
    end
    prime_rd_q <= prime_mem[prime_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      pres_rvld_q <= 1'b0;
      out_vld_q   <= 1'b0;
      m_q         <= '0;
      last_m_q    <= '0;
      rem_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pres_rvld_q <= valid_q[pres_raddr];
      out_vld_q   <= out_vld_d;
      m_q         <= m_d;
      last_m_q    <= last_m_d;
      rem_q       <= rem_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q         <= b_d;
    cur_q       <= cur_d;
    merged_q    <= merged_d;
    work_q      <= work_d;
    out_val_q   <= out_val_d;
    out_msk_q   <= out_msk_d;
    out_last_q  <= out_last_d;
    out_trunc_q <= out_trunc_d;
    out_empty_q <= out_empty_d;
  end

  assign valid_o           = out_vld_q;
  assign implicant_value_o = out_val_q;
  assign dont_care_mask_o  = out_msk_q;
  assign last_implicant_o  = out_last_q;
  assign truncated_o       = out_trunc_q;
  assign empty_function_o  = out_empty_q;

endmodule
